[src/tdmf_pkg.sv]
// ----------------------------------------------------------------------------
// tdmf_pkg
// Shared types, codes and the CRC-16/ARC byte step for the dose message framer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdmf_pkg;

    localparam int unsigned MsgBytes = 6;
    localparam logic [15:0] CrcPoly  = 16'hA001;   // reflected form of 0x8005
    localparam logic [15:0] CrcSeed  = 16'h0000;
    localparam logic [15:0] DelayRst = 16'd10;
    localparam logic [15:0] CountMax = 16'hFFFF;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_TRIGGER = 1'b1
    } t_opcode;

    // register index = paddr[4:3]
    typedef enum logic [1:0] {
        REG_DELAY  = 2'd0,
        REG_TBL_LO = 2'd1,
        REG_TBL_HI = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        BYTE_DOSE   = 3'd0,
        BYTE_ENERGY = 3'd1,
        BYTE_PAD0   = 3'd2,
        BYTE_PAD1   = 3'd3,
        BYTE_CRC_LO = 3'd4,
        BYTE_CRC_HI = 3'd5
    } t_byte_sel;

    typedef struct packed {
        logic [15:0] transmit_delay;
        logic [63:0] dose_table_low;
        logic [63:0] dose_table_high;
    } t_cfg;

    // one pending message: the CRC follows from these two bytes
    typedef struct packed {
        logic [7:0] dose;
        logic       energy;
    } t_msg_rec;

    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[src/tdmf_if.sv]
// ----------------------------------------------------------------------------
// tdmf_if
// Valid/ready channels for trigger/tick requests and message bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdmf_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [3:0] dose_select;

    modport source (output valid, output opcode, output dose_select, input ready);
    modport sink   (input valid, input opcode, input dose_select, output ready);
endinterface

interface tdmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (output valid, output tx_byte, output last_byte, input ready);
    modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[src/tdmf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tdmf_cfg_regs
// APB register file: transmit delay and the two packed dose table words.
// ----------------------------------------------------------------------------
`default_nettype none

module tdmf_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic      [63:0]   prdata,
    output logic               pready,
    output tdmf_pkg::t_cfg     o_cfg
);
    import tdmf_pkg::*;

    logic [15:0] r_delay;
    logic [63:0] r_tbl_lo;
    logic [63:0] r_tbl_hi;
    logic        w_wr;
    t_reg_idx    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DelayRst;
            r_tbl_lo <= '0;
            r_tbl_hi <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_DELAY:  r_delay  <= pwdata[15:0];
                REG_TBL_LO: r_tbl_lo <= pwdata;
                REG_TBL_HI: r_tbl_hi <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DELAY:  prdata = {48'h0, r_delay};
            REG_TBL_LO: prdata = r_tbl_lo;
            REG_TBL_HI: prdata = r_tbl_hi;
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.transmit_delay  = r_delay;
    assign o_cfg.dose_table_low  = r_tbl_lo;
    assign o_cfg.dose_table_high = r_tbl_hi;

endmodule

`default_nettype wire

[src/tdmf_front.sv]
// ----------------------------------------------------------------------------
// tdmf_front
// Takes ticks and triggers, keeps energy/wait/count/dose state and queues a
// message record when the delay count reaches the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module tdmf_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tdmf_pkg::t_cfg     i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_opcode,
    input  wire logic [3:0]         i_dose_select,
    input  wire logic               i_queue_full,
    output logic                    o_push,
    output tdmf_pkg::t_msg_rec      o_rec
);
    import tdmf_pkg::*;

    logic        r_energy, n_energy;
    logic        r_waiting, n_waiting;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_dose, n_dose;
    logic        w_accept;
    logic [63:0] w_word;
    logic [7:0]  w_lookup;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;

    assign w_word   = i_dose_select[3] ? i_cfg.dose_table_high : i_cfg.dose_table_low;
    assign w_lookup = w_word[{i_dose_select[2:0], 3'b000} +: 8];

    always_comb begin
        n_energy  = r_energy;
        n_waiting = r_waiting;
        n_count   = r_count;
        n_dose    = r_dose;
        o_push    = 1'b0;
        if (w_accept) begin
            case (t_opcode'(i_opcode))
                OP_TICK: begin
                    if (r_waiting && r_count != CountMax) begin
                        n_count = r_count + 16'd1;
                    end
                end
                OP_TRIGGER: begin
                    n_waiting = 1'b1;
                    n_energy  = ~r_energy;
                    n_dose    = w_lookup;
                end
                default: ;
            endcase
            if (n_count >= i_cfg.transmit_delay) begin
                o_push    = 1'b1;
                n_count   = '0;
                n_waiting = 1'b0;
            end
        end
    end

    assign o_rec.dose   = n_dose;
    assign o_rec.energy = n_energy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy  <= 1'b0;
            r_waiting <= 1'b0;
            r_count   <= '0;
            r_dose    <= '0;
        end else begin
            r_energy  <= n_energy;
            r_waiting <= n_waiting;
            r_count   <= n_count;
            r_dose    <= n_dose;
        end
    end

    a_push_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_count == '0) && !r_waiting)
        else $error("front: count or wait flag not cleared after a send");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_queue_full |-> !o_push)
        else $error("front: message queued while queue full");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_waiting && !w_accept) |=> $stable(r_count))
        else $error("front: count moved while idle");

endmodule

`default_nettype wire

[src/tdmf_msg_fifo.sv]
// ----------------------------------------------------------------------------
// tdmf_msg_fifo
// Short queue of pending message records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tdmf_msg_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire tdmf_pkg::t_msg_rec i_rec,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output tdmf_pkg::t_msg_rec      o_rec
);
    import tdmf_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

    t_msg_rec        r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + PtrW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("fifo: push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("fifo: pop while empty");

endmodule

`default_nettype wire

[src/tdmf_back.sv]
// ----------------------------------------------------------------------------
// tdmf_back
// Serializes one message record into six bytes, folding each of the first
// four into a running CRC-16/ARC that supplies the last two.
// ----------------------------------------------------------------------------
`default_nettype none

module tdmf_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rec_valid,
    input  wire tdmf_pkg::t_msg_rec i_rec,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_tx_byte,
    output logic                    o_last_byte
);
    import tdmf_pkg::*;

    logic        r_busy;
    t_byte_sel   r_idx;
    logic [15:0] r_crc;
    t_msg_rec    r_rec;
    logic        w_take;
    logic        w_done;

    assign o_valid = r_busy;
    assign w_take  = o_valid && i_ready;
    assign w_done  = w_take && (r_idx == BYTE_CRC_HI);
    assign o_pop   = i_rec_valid && (!r_busy || w_done);

    always_comb begin
        case (r_idx)
            BYTE_DOSE:   o_tx_byte = r_rec.dose;
            BYTE_ENERGY: o_tx_byte = {7'h00, r_rec.energy};
            BYTE_PAD0:   o_tx_byte = 8'h00;
            BYTE_PAD1:   o_tx_byte = 8'h00;
            BYTE_CRC_LO: o_tx_byte = r_crc[7:0];
            BYTE_CRC_HI: o_tx_byte = r_crc[15:8];
            default:     o_tx_byte = 8'h00;
        endcase
    end

    assign o_last_byte = (r_idx == BYTE_CRC_HI);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= BYTE_DOSE;
            r_crc  <= CrcSeed;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= BYTE_DOSE;
            r_crc  <= CrcSeed;
        end else if (w_done) begin
            r_busy <= 1'b0;
            r_idx  <= BYTE_DOSE;
        end else if (w_take) begin
            r_idx <= t_byte_sel'(r_idx + 3'd1);
            // CRC covers the four payload bytes only
            if (r_idx < BYTE_CRC_LO) begin
                r_crc <= crc_add_byte(r_crc, o_tx_byte);
            end
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx <= BYTE_CRC_HI))
        else $error("back: byte index out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_idx) && $stable(r_crc))
        else $error("back: state moved while output stalled");

    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_busy) |-> w_done)
        else $error("back: new record loaded mid-message");

endmodule

`default_nettype wire

[src/trigger_dose_message_framer.sv]
// ----------------------------------------------------------------------------
// trigger_dose_message_framer
// Trigger/tick driven six-byte dose message framer with CRC-16/ARC.
//
//   port      dir  kind          payload
//   i_in      in   valid/ready   opcode[0], dose_select[3:0]
//   o_out     out  valid/ready   tx_byte[7:0], last_byte
//   psel..    in   APB write/rd  transmit_delay @0x00, dose tables @0x08, 0x10
//
// An input request is taken in the cycle it is valid with ready high; ready
// drops only while the message queue (FIFO_DEPTH records) is full. A request
// that sends queues its record at once; the byte serializer loads it from the
// queue head when free and sends its six bytes, then starts the next message
// without a gap. Synchronous active-low reset; no clearing pass. Output stalls
// fill the queue first and reach the input ready only once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module trigger_dose_message_framer #(
    parameter int unsigned FIFO_DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    tdmf_in_if.sink            i_in,
    tdmf_out_if.source         o_out,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic      [63:0]   prdata,
    output logic               pready
);
    import tdmf_pkg::*;

    t_cfg     w_cfg;
    t_msg_rec w_push_rec, w_head_rec;
    logic     w_push, w_full, w_pop, w_head_valid;

    tdmf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tdmf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_opcode      (i_in.opcode),
        .i_dose_select (i_in.dose_select),
        .i_queue_full  (w_full),
        .o_push        (w_push),
        .o_rec         (w_push_rec)
    );

    tdmf_msg_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_rec   (w_head_rec)
    );

    tdmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (w_head_valid),
        .i_rec       (w_head_rec),
        .o_pop       (w_pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_tx_byte   (o_out.tx_byte),
        .o_last_byte (o_out.last_byte)
    );

endmodule

`default_nettype wire
